// File: rtl/core/sacf_pkg.sv
// Shared types, constants and per-lane functions of the swept box first-contact pipeline.
`default_nettype none
package sacf_pkg;

   localparam int PosWidth = 24;
   localparam int SizeWidth = 20;
   localparam int VelWidth = 21;
   localparam int EdgeWidth = PosWidth + 1;
   localparam int DiffWidth = PosWidth + 2;
   localparam int MagWidth = VelWidth;
   localparam int QuoWidth = 16;
   localparam int TimeWidth = QuoWidth + 1;
   localparam int BitsPerStage = 2;
   localparam int DivStages = QuoWidth / BitsPerStage;
   localparam int NumStages = DivStages + 3;

   localparam logic [TimeWidth-1:0] ONE_FRAME = TimeWidth'(65536);
   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   typedef struct packed {
      logic                        still;
      logic                        fail;
      logic [MagWidth-1:0]         mag;
      logic signed [DiffWidth-1:0] en;
      logic signed [DiffWidth-1:0] ex;
   } setup_axis_type;

   typedef struct packed {
      setup_axis_type x;
      setup_axis_type y;
      logic           blocked;
   } setup_type;

   typedef struct packed {
      logic                zero;
      logic                sat;
      logic [MagWidth-1:0] rem;
      logic [QuoWidth-1:0] quo;
   } lane_type;

   typedef struct packed {
      logic                still;
      logic [MagWidth-1:0] mag;
      lane_type            en;
      lane_type            ex;
   } div_axis_type;

   typedef struct packed {
      div_axis_type x;
      div_axis_type y;
      logic         fail;
   } pipe_type;

   function automatic setup_axis_type axis_setup(
      input logic signed [VelWidth-1:0] v,
      input logic signed [PosWidth-1:0] pos_a,
      input logic [SizeWidth-1:0]       size_a,
      input logic signed [PosWidth-1:0] pos_b,
      input logic [SizeWidth-1:0]       size_b
   );
      setup_axis_type r;
      logic signed [DiffWidth-1:0] amin;
      logic signed [DiffWidth-1:0] amax;
      logic signed [DiffWidth-1:0] bmin;
      logic signed [DiffWidth-1:0] bmax;
      logic [VelWidth:0] nv;
      amin = DiffWidth'(pos_a);
      bmin = DiffWidth'(pos_b);
      amax = amin + $signed({{(DiffWidth-SizeWidth){1'b0}}, size_a});
      bmax = bmin + $signed({{(DiffWidth-SizeWidth){1'b0}}, size_b});
      nv = -{v[VelWidth-1], v};
      r.still = (v == '0);
      if (v == '0) begin
         r.fail = !((bmin <= amax) && (amin <= bmax));
         r.mag = '0;
         r.en = '0;
         r.ex = '0;
      end else if (v[VelWidth-1]) begin
         r.fail = (amax < bmin);
         r.mag = nv[MagWidth-1:0];
         r.en = amin - bmax;
         r.ex = amax - bmin;
      end else begin
         r.fail = (amin > bmax);
         r.mag = v[MagWidth-1:0];
         r.en = bmin - amax;
         r.ex = bmax - amin;
      end
      return r;
   endfunction

   function automatic lane_type lane_init(
      input logic signed [DiffWidth-1:0] n,
      input logic [MagWidth-1:0]         mag,
      input logic                        still
   );
      lane_type r;
      r.zero = still || n[DiffWidth-1] || (n == '0);
      r.sat = !r.zero && (n[DiffWidth-2:0] >= {{(DiffWidth-1-MagWidth){1'b0}}, mag});
      r.rem = n[MagWidth-1:0];
      r.quo = '0;
      return r;
   endfunction

   function automatic lane_type lane_step(
      input lane_type            l,
      input logic [MagWidth-1:0] mag
   );
      lane_type r;
      logic [MagWidth:0] t;
      r = l;
      for (int i = 0; i < BitsPerStage; i++) begin
         t = {r.rem, 1'b0};
         if (t >= {1'b0, mag}) begin
            t = t - {1'b0, mag};
            r.quo = {r.quo[QuoWidth-2:0], 1'b1};
         end else begin
            r.quo = {r.quo[QuoWidth-2:0], 1'b0};
         end
         r.rem = t[MagWidth-1:0];
      end
      return r;
   endfunction

   function automatic logic [TimeWidth-1:0] lane_time(input lane_type l);
      if (l.zero) begin
         return '0;
      end else if (l.sat) begin
         return ONE_FRAME;
      end
      return {1'b0, l.quo};
   endfunction

endpackage
`default_nettype wire

// File: rtl/core/sacf_setup.sv
// First stage: box edges, per-axis distances, speed magnitude and early rejects.
`default_nettype none
module sacf_setup (
   input  wire logic                                  clock,
   input  wire logic                                  load,
   input  wire logic signed [sacf_pkg::PosWidth-1:0]  a_x,
   input  wire logic signed [sacf_pkg::PosWidth-1:0]  a_y,
   input  wire logic [sacf_pkg::SizeWidth-1:0]        a_width,
   input  wire logic [sacf_pkg::SizeWidth-1:0]        a_height,
   input  wire logic signed [sacf_pkg::PosWidth-1:0]  b_x,
   input  wire logic signed [sacf_pkg::PosWidth-1:0]  b_y,
   input  wire logic [sacf_pkg::SizeWidth-1:0]        b_width,
   input  wire logic [sacf_pkg::SizeWidth-1:0]        b_height,
   input  wire logic signed [sacf_pkg::VelWidth-1:0]  rel_vel_x,
   input  wire logic signed [sacf_pkg::VelWidth-1:0]  rel_vel_y,
   input  wire logic                                  pair_blocked,
   output sacf_pkg::setup_type                        setup_out
);
   import sacf_pkg::*;

   setup_type setup_ff;
   setup_type setup_in;

   always_comb begin
      setup_in.x = axis_setup(rel_vel_x, a_x, a_width, b_x, b_width);
      setup_in.y = axis_setup(rel_vel_y, a_y, a_height, b_y, b_height);
      setup_in.blocked = pair_blocked;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         setup_ff <= setup_in;
      end
   end

   assign setup_out = setup_ff;

endmodule
`default_nettype wire

// File: rtl/core/sacf_prep.sv
// Divider preparation: zero and saturation detection and lane initialization.
`default_nettype none
module sacf_prep (
   input  wire logic                clock,
   input  wire logic                load,
   input  sacf_pkg::setup_type      setup_in,
   output sacf_pkg::pipe_type       pipe_out
);
   import sacf_pkg::*;

   pipe_type pipe_ff;
   pipe_type pipe_in;

   always_comb begin
      pipe_in.x.still = setup_in.x.still;
      pipe_in.x.mag = setup_in.x.mag;
      pipe_in.x.en = lane_init(setup_in.x.en, setup_in.x.mag, setup_in.x.still);
      pipe_in.x.ex = lane_init(setup_in.x.ex, setup_in.x.mag, setup_in.x.still);
      pipe_in.y.still = setup_in.y.still;
      pipe_in.y.mag = setup_in.y.mag;
      pipe_in.y.en = lane_init(setup_in.y.en, setup_in.y.mag, setup_in.y.still);
      pipe_in.y.ex = lane_init(setup_in.y.ex, setup_in.y.mag, setup_in.y.still);
      pipe_in.fail = setup_in.blocked || setup_in.x.fail || setup_in.y.fail;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pipe_ff <= pipe_in;
      end
   end

   assign pipe_out = pipe_ff;

endmodule
`default_nettype wire

// File: rtl/core/sacf_div_step.sv
// One divider stage: two restoring quotient bits on all four time lanes.
`default_nettype none
module sacf_div_step (
   input  wire logic           clock,
   input  wire logic           load,
   input  sacf_pkg::pipe_type  pipe_in,
   output sacf_pkg::pipe_type  pipe_out
);
   import sacf_pkg::*;

   pipe_type pipe_ff;
   pipe_type step_in;

   always_comb begin
      step_in = pipe_in;
      step_in.x.en = lane_step(pipe_in.x.en, pipe_in.x.mag);
      step_in.x.ex = lane_step(pipe_in.x.ex, pipe_in.x.mag);
      step_in.y.en = lane_step(pipe_in.y.en, pipe_in.y.mag);
      step_in.y.ex = lane_step(pipe_in.y.ex, pipe_in.y.mag);
   end

   always_ff @(posedge clock) begin
      if (load) begin
         pipe_ff <= step_in;
      end
   end

   assign pipe_out = pipe_ff;

endmodule
`default_nettype wire

// File: rtl/core/sacf_resolve.sv
// Final stage: entry and exit time merge, axis choice and result register.
`default_nettype none
module sacf_resolve (
   input  wire logic                             clock,
   input  wire logic                             load,
   input  sacf_pkg::pipe_type                    pipe_in,
   output logic                                  hit,
   output logic [sacf_pkg::TimeWidth-1:0]        hit_time,
   output logic                                  hit_axis
);
   import sacf_pkg::*;

   logic                 hit_ff;
   logic [TimeWidth-1:0] time_ff;
   logic                 axis_ff;
   logic                 hit_in;
   logic [TimeWidth-1:0] time_in;
   logic                 axis_in;
   logic [TimeWidth-1:0] start;
   logic [TimeWidth-1:0] stop;
   logic [TimeWidth-1:0] te_y;
   logic [TimeWidth-1:0] tx_y;
   logic                 axis;

   always_comb begin
      start = lane_time(pipe_in.x.en);
      stop = pipe_in.x.still ? ONE_FRAME : lane_time(pipe_in.x.ex);
      axis = AXIS_X;
      te_y = lane_time(pipe_in.y.en);
      tx_y = lane_time(pipe_in.y.ex);
      if (!pipe_in.y.still) begin
         if (te_y > start) begin
            start = te_y;
            axis = AXIS_Y;
         end
         if (tx_y < stop) begin
            stop = tx_y;
         end
      end
      hit_in = !pipe_in.fail && (start < stop);
      time_in = hit_in ? start : '0;
      axis_in = hit_in ? axis : AXIS_X;
   end

   always_ff @(posedge clock) begin
      if (load) begin
         hit_ff <= hit_in;
         time_ff <= time_in;
         axis_ff <= axis_in;
      end
   end

   assign hit = hit_ff;
   assign hit_time = time_ff;
   assign hit_axis = axis_ff;

endmodule
`default_nettype wire

// File: rtl/core/swept_aabb_first_contact_top.sv
// Swept box first-contact test: one box pair in, one contact result out.
// The block takes one box pair per cycle unless it stalls, and passes it through
// one setup stage, one divider preparation stage, eight divider stages
// that each resolve two quotient bits of the four entry and exit times, and a
// result stage. A stall at the output reaches the input in the same cycle
// through a chain of ready signals, and empty stages keep filling while the
// output waits.
`default_nettype none
module swept_aabb_first_contact_top (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic signed [sacf_pkg::PosWidth-1:0] req_a_x,
   input  wire logic signed [sacf_pkg::PosWidth-1:0] req_a_y,
   input  wire logic [sacf_pkg::SizeWidth-1:0]       req_a_width,
   input  wire logic [sacf_pkg::SizeWidth-1:0]       req_a_height,
   input  wire logic signed [sacf_pkg::PosWidth-1:0] req_b_x,
   input  wire logic signed [sacf_pkg::PosWidth-1:0] req_b_y,
   input  wire logic [sacf_pkg::SizeWidth-1:0]       req_b_width,
   input  wire logic [sacf_pkg::SizeWidth-1:0]       req_b_height,
   input  wire logic signed [sacf_pkg::VelWidth-1:0] req_rel_vel_x,
   input  wire logic signed [sacf_pkg::VelWidth-1:0] req_rel_vel_y,
   input  wire logic                                 req_pair_blocked,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic                                      rsp_hit,
   output logic [sacf_pkg::TimeWidth-1:0]            rsp_hit_time,
   output logic                                      rsp_hit_axis
);
   import sacf_pkg::*;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] ready;
   setup_type            setup;
   pipe_type             pipe [DivStages+1];

   always_comb begin
      ready[NumStages-1] = !valid_ff[NumStages-1] || !rsp_stall;
      for (int k = NumStages - 2; k >= 0; k--) begin
         ready[k] = !valid_ff[k] || ready[k+1];
      end
      valid_in[0] = req_valid;
      for (int k = 1; k < NumStages; k++) begin
         valid_in[k] = valid_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         for (int k = 0; k < NumStages; k++) begin
            if (ready[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end
      end
   end

   assign req_stall = !ready[0];
   assign rsp_valid = valid_ff[NumStages-1];

   sacf_setup u_setup (
      .clock        (clock),
      .load         (ready[0]),
      .a_x          (req_a_x),
      .a_y          (req_a_y),
      .a_width      (req_a_width),
      .a_height     (req_a_height),
      .b_x          (req_b_x),
      .b_y          (req_b_y),
      .b_width      (req_b_width),
      .b_height     (req_b_height),
      .rel_vel_x    (req_rel_vel_x),
      .rel_vel_y    (req_rel_vel_y),
      .pair_blocked (req_pair_blocked),
      .setup_out    (setup)
   );

   sacf_prep u_prep (
      .clock    (clock),
      .load     (ready[1]),
      .setup_in (setup),
      .pipe_out (pipe[0])
   );

   for (genvar s = 0; s < DivStages; s++) begin : g_div
      sacf_div_step u_step (
         .clock    (clock),
         .load     (ready[s+2]),
         .pipe_in  (pipe[s]),
         .pipe_out (pipe[s+1])
      );
   end

   sacf_resolve u_resolve (
      .clock    (clock),
      .load     (ready[NumStages-1]),
      .pipe_in  (pipe[DivStages]),
      .hit      (rsp_hit),
      .hit_time (rsp_hit_time),
      .hit_axis (rsp_hit_axis)
   );

   a_hit_before_frame_end : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_hit_time < ONE_FRAME)
      else $error("Hit reported at or after the end of the frame.");

   a_miss_is_clean : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_hit_time == '0 && rsp_hit_axis == AXIS_X)
      else $error("Miss transaction carries a nonzero time or axis.");

   a_held_stage_keeps_valid : assert property (@(posedge clock) disable iff (reset)
      valid_ff[1] && !ready[1] |=> valid_ff[1])
      else $error("A stalled pipeline stage dropped its transaction.");

endmodule
`default_nettype wire

// File: sim/swept_aabb_first_contact_checker.sv
// Checker that predicts swept box contact results and compares them with the block outputs.
module swept_aabb_first_contact_checker (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   input  logic                                 req_stall,
   input  logic signed [sacf_pkg::PosWidth-1:0] req_a_x,
   input  logic signed [sacf_pkg::PosWidth-1:0] req_a_y,
   input  logic [sacf_pkg::SizeWidth-1:0]       req_a_width,
   input  logic [sacf_pkg::SizeWidth-1:0]       req_a_height,
   input  logic signed [sacf_pkg::PosWidth-1:0] req_b_x,
   input  logic signed [sacf_pkg::PosWidth-1:0] req_b_y,
   input  logic [sacf_pkg::SizeWidth-1:0]       req_b_width,
   input  logic [sacf_pkg::SizeWidth-1:0]       req_b_height,
   input  logic signed [sacf_pkg::VelWidth-1:0] req_rel_vel_x,
   input  logic signed [sacf_pkg::VelWidth-1:0] req_rel_vel_y,
   input  logic                                 req_pair_blocked,
   input  logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   input  logic                                 rsp_hit,
   input  logic [sacf_pkg::TimeWidth-1:0]       rsp_hit_time,
   input  logic                                 rsp_hit_axis,
   output int                                   fail_count,
   output int                                   pending_count,
   output int                                   hit_count
);
   timeunit 1ns;
   timeprecision 1ps;
   import sacf_pkg::*;

   typedef struct packed {
      logic                 hit;
      logic [TimeWidth-1:0] hit_time;
      logic                 axis;
   } contact_type;

   contact_type expected_contacts[$];

   initial begin
      fail_count = 0;
      hit_count = 0;
   end

   assign pending_count = expected_contacts.size();

   function automatic longint frame_fraction(longint span, longint speed);
      longint q;
      if (span <= 0) return 0;
      q = (span * 65536) / speed;
      return (q > 65536) ? 65536 : q;
   endfunction

   function automatic bit sweep_axis(longint v, longint mmin, longint mmax, longint smin,
                                     longint smax, logic code, inout longint t_in,
                                     inout longint t_out, inout logic axis);
      longint dist_in, dist_out, speed, te, tx;
      if (v == 0) return (smin <= mmax) && (mmin <= smax);
      if (v < 0) begin
         if (mmax < smin) return 0;
         speed = -v;
         dist_in = mmin - smax;
         dist_out = mmax - smin;
      end else begin
         if (mmin > smax) return 0;
         speed = v;
         dist_in = smin - mmax;
         dist_out = smax - mmin;
      end
      te = frame_fraction(dist_in, speed);
      tx = frame_fraction(dist_out, speed);
      if (te > t_in) begin
         t_in = te;
         axis = code;
      end
      if (tx < t_out) t_out = tx;
      return 1;
   endfunction

   function automatic contact_type predict_contact();
      contact_type c;
      longint t_in, t_out, ax, ay, bx, by;
      logic axis;
      t_in = 0;
      t_out = 65536;
      axis = AXIS_X;
      ax = req_a_x;
      ay = req_a_y;
      bx = req_b_x;
      by = req_b_y;
      c = '0;
      if (!req_pair_blocked
          && sweep_axis(req_rel_vel_x, ax, ax + req_a_width, bx, bx + req_b_width,
                        AXIS_X, t_in, t_out, axis)
          && sweep_axis(req_rel_vel_y, ay, ay + req_a_height, by, by + req_b_height,
                        AXIS_Y, t_in, t_out, axis)
          && t_in < t_out) begin
         c.hit = 1'b1;
         c.hit_time = TimeWidth'(t_in);
         c.axis = axis;
      end
      return c;
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("%0t mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
      fail_count++;
   endtask

   always @(posedge clock) begin
      contact_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_contacts.size() == 0) begin
               report_mismatch("unexpected transaction", 1, 0);
            end else begin
               want = expected_contacts.pop_front();
               if (rsp_hit !== want.hit) report_mismatch("hit", rsp_hit, want.hit);
               if (rsp_hit_time !== want.hit_time)
                  report_mismatch("hit_time", rsp_hit_time, want.hit_time);
               if (rsp_hit_axis !== want.axis) report_mismatch("hit_axis", rsp_hit_axis, want.axis);
               if (want.hit) hit_count++;
            end
         end
         if (req_valid && !req_stall)
            expected_contacts.insert(expected_contacts.size(), predict_contact());
      end
   end
endmodule

// File: sim/tb_swept_aabb_first_contact_top.sv
// Testbench top for the swept box first-contact block: stimulus, idling and verdict.
module tb_swept_aabb_first_contact_top;
   timeunit 1ns;
   timeprecision 1ps;
   import sacf_pkg::*;

   localparam int CycleLimit = 400000;
   localparam int RandomPairs = 950;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [PosWidth-1:0] req_a_x = '0, req_a_y = '0, req_b_x = '0, req_b_y = '0;
   logic [SizeWidth-1:0] req_a_width = '0, req_a_height = '0;
   logic [SizeWidth-1:0] req_b_width = '0, req_b_height = '0;
   logic signed [VelWidth-1:0] req_rel_vel_x = '0, req_rel_vel_y = '0;
   logic req_pair_blocked = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic rsp_hit;
   logic [TimeWidth-1:0] rsp_hit_time;
   logic rsp_hit_axis;
   int fail_count, pending_count, hit_count;
   int cycle_count = 0;
   int pair_count = 0;

   always #6 clock = ~clock;

   swept_aabb_first_contact_top dut (.*);
   swept_aabb_first_contact_checker checker_inst (.*);

   function automatic int gap_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILED: results differ");
         $finish;
      end
   end

   initial begin
      int g;
      forever begin
         @(posedge clock);
         if (cycle_count % 2000 < 300) begin
            rsp_stall <= 1'b0;
         end else begin
            g = gap_length();
            if (g > 0) begin
               rsp_stall <= 1'b1;
               repeat (g) @(posedge clock);
            end
            rsp_stall <= 1'b0;
         end
      end
   end

   task automatic send_pair(input logic [23:0] ax, ay, bx, by,
                            input logic [19:0] aw, ah, bw, bh,
                            input logic [20:0] vx, vy, input logic blk);
      int g;
      g = (pair_count % 300 < 40) ? 0 : gap_length();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_a_x <= ax;
      req_a_y <= ay;
      req_b_x <= bx;
      req_b_y <= by;
      req_a_width <= aw;
      req_a_height <= ah;
      req_b_width <= bw;
      req_b_height <= bh;
      req_rel_vel_x <= vx;
      req_rel_vel_y <= vy;
      req_pair_blocked <= blk;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pair_count++;
   endtask

   function automatic logic [20:0] pick_velocity();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r < 7) return 21'($signed($urandom_range(0, 16000)) - 8000);
      return 21'($urandom);
   endfunction

   task automatic send_random_pair();
      logic [23:0] ax, ay, bx, by;
      logic [20:0] vx, vy;
      int kind;
      kind = $urandom_range(0, 9);
      bx = 24'($signed($urandom_range(0, 40000)) - 20000);
      by = 24'($signed($urandom_range(0, 40000)) - 20000);
      vx = pick_velocity();
      vy = pick_velocity();
      if (kind < 7) begin
         ax = bx - 24'($signed(vx) / 2) + 24'($signed($urandom_range(0, 4000)) - 2000);
         ay = by - 24'($signed(vy) / 2) + 24'($signed($urandom_range(0, 4000)) - 2000);
         send_pair(ax, ay, bx, by, 20'($urandom_range(0, 3000)), 20'($urandom_range(0, 3000)),
                   20'($urandom_range(0, 3000)), 20'($urandom_range(0, 3000)), vx, vy,
                   $urandom_range(0, 9) == 0);
      end else begin
         send_pair(24'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
                   20'($urandom), 20'($urandom), 20'($urandom), 20'($urandom),
                   21'($urandom), 21'($urandom), 1'($urandom));
      end
   endtask

   initial begin
      int drain;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      // Extremes of every field, touching and separating cases, ties and saturation.
      send_pair(24'h7FFFFF, 24'h800000, 24'h800000, 24'h7FFFFF, '1, '1, '1, '1,
                21'h0FFFFF, 21'h100000, 1'b0);
      send_pair(24'h800000, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, '1, '1, '1, '1,
                21'h0FFFFF, 21'h0FFFFF, 1'b0);
      send_pair('0, '0, 24'd256, '0, 20'd256, 20'd256, 20'd256, 20'd256, '0, '0, 1'b0);
      send_pair('0, '0, 24'd257, '0, 20'd256, 20'd256, 20'd256, 20'd256, '0, '0, 1'b0);
      send_pair('0, '0, '0, '0, 20'd256, 20'd256, 20'd256, 20'd256, '0, '0, 1'b1);
      send_pair('0, '0, 24'd1000, '0, 20'd100, 20'd100, 20'd100, 20'd100, 21'd1800, '0, 1'b0);
      send_pair('0, '0, 24'd1000, '0, 20'd100, 20'd100, 20'd100, 20'd100, 21'd100, '0, 1'b0);
      send_pair(24'd1000, '0, '0, '0, 20'd100, 20'd100, 20'd100, 20'd100, 21'd50, '0, 1'b0);
      send_pair(24'd1000, '0, '0, '0, 20'd100, 20'd100, 20'd100, 20'd100, -21'sd1800, '0, 1'b0);
      send_pair('0, '0, 24'd1000, '0, 20'd100, 20'd100, 20'd100, 20'd100, -21'sd50, '0, 1'b0);
      send_pair('0, '0, 24'd500, 24'd500, 20'd100, 20'd100, 20'd100, 20'd100,
                21'd800, 21'd800, 1'b0);
      send_pair('0, '0, 24'd500, 24'd700, 20'd100, 20'd100, 20'd100, 20'd100,
                21'd800, 21'd800, 1'b0);
      send_pair('0, '0, 24'd50, 24'd50, 20'd100, 20'd100, 20'd100, 20'd100,
                21'd3, -21'sd7, 1'b0);
      send_pair('0, '0, 24'd1, '0, '0, '0, '0, '0, 21'd1, 21'd0, 1'b0);
      send_pair('0, '0, 24'd300, 24'd300, 20'd100, 20'd100, 20'd100, 20'd100,
                21'h0FFFFF, 21'h100000, 1'b1);
      repeat (RandomPairs) send_random_pair();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      drain = 0;
      while (drain < 40) begin
         @(posedge clock);
         drain++;
      end
      $display("Sent %0d box pairs, %0d of them reported a contact.", pair_count, hit_count);
      if (fail_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end
endmodule
